>>> hdl/bpq_pkg.sv
package bpq_pkg;

  localparam int CMD_W    = 2;
  localparam int ITEM_W   = 32;
  localparam int WEIGHT_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic [ITEM_W-1:0]          item;
    logic signed [WEIGHT_W-1:0] weight;
  } bpq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic                       bumped_valid;
    logic [ITEM_W-1:0]          bumped_item;
    logic [ITEM_W-1:0]          out_item;
    logic signed [WEIGHT_W-1:0] out_weight;
    logic [COUNT_W-1:0]         count;
    logic                       empty_res;
  } bpq_out_t;

  // sequencer status towards the top level
  typedef struct packed {
    logic ready;
    logic res_valid;
  } bpq_stat_t;

endpackage

>>> hdl/bpq_seq.sv
module bpq_seq #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start_i,
  input  bpq_pkg::bpq_in_t        req_i,
  input  logic [bpq_pkg::CAP_W-1:0] cap_i,
  input  logic                    res_ready_i,
  output bpq_pkg::bpq_stat_t      stat_o,
  output bpq_pkg::bpq_out_t       res_o
);
  import bpq_pkg::*;

  localparam int KW = (ITEM_WIDTH < ITEM_W) ? ITEM_WIDTH : ITEM_W;
  localparam int EW = KW + WEIGHT_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EVICT, S_INS_WALK, S_INS_HEAD, S_UPD_SCAN, S_POP_HEAD, S_POP_WALK, S_DONE
  } state_t;

  // entry store: {item, weight}, one read and one write port, registered read
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [EW-1:0] mem_wr_data;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              j_r, j_nxt;
  logic [KW-1:0]              item_r, item_nxt;
  logic signed [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                       upd_r, upd_nxt;
  logic [EW-1:0]              prev_r, prev_nxt;
  logic [STATUS_W-1:0]        status_r, status_nxt;
  logic                       bv_r, bv_nxt;
  logic [KW-1:0]              bitem_r, bitem_nxt;
  logic [KW-1:0]              oitem_r, oitem_nxt;
  logic signed [WEIGHT_W-1:0] ow_r, ow_nxt;

  logic [CW-1:0]              cap_eff;
  logic [KW-1:0]              rd_it;
  logic signed [WEIGHT_W-1:0] rd_w;
  logic signed [WEIGHT_W-1:0] prev_w;
  logic [EW-1:0]              new_ent;
  logic [EW-1:0]              req_ent;

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    rd_data_r <= mem[mem_rd_addr];
  end

  always_comb begin
    if (cap_i == '0) begin
      cap_eff = CW'(1);
    end else if ({27'd0, cap_i} > 32'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_i);
    end
  end

  assign rd_it   = rd_data_r[EW-1:WEIGHT_W];
  assign rd_w    = rd_data_r[WEIGHT_W-1:0];
  assign prev_w  = prev_r[WEIGHT_W-1:0];
  assign new_ent = {item_r, weight_r};
  assign req_ent = {req_i.item[KW-1:0], req_i.weight};

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    j_nxt       = j_r;
    item_nxt    = item_r;
    weight_nxt  = weight_r;
    upd_nxt     = upd_r;
    prev_nxt    = prev_r;
    status_nxt  = status_r;
    bv_nxt      = bv_r;
    bitem_nxt   = bitem_r;
    oitem_nxt   = oitem_r;
    ow_nxt      = ow_r;
    mem_rd_addr = j_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = j_r;
    mem_wr_data = new_ent;

    case (state_r)
      S_IDLE: begin
        mem_rd_addr = (req_i.command == CMD_INSERT) ? AW'(count_r - CW'(1)) : '0;
        if (start_i) begin
          item_nxt   = req_i.item[KW-1:0];
          weight_nxt = req_i.weight;
          upd_nxt    = 1'b0;
          status_nxt = ST_OK;
          bv_nxt     = 1'b0;
          bitem_nxt  = '0;
          oitem_nxt  = '0;
          ow_nxt     = '0;
          j_nxt      = '0;
          case (req_i.command)
            CMD_INSERT: begin
              if (count_r < cap_eff) begin
                if (count_r == '0) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = '0;
                  mem_wr_data = req_ent;
                  count_nxt   = count_r + CW'(1);
                  state_nxt   = S_DONE;
                end else begin
                  j_nxt     = AW'(count_r - CW'(1));
                  state_nxt = S_INS_WALK;
                end
              end else begin
                state_nxt = S_EVICT;
              end
            end
            CMD_UPDATE: begin
              if (count_r == '0) begin
                status_nxt = ST_NOTFOUND;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_UPD_SCAN;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_POP_HEAD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // last entry is on the read port
      S_EVICT: begin
        if (weight_r < rd_w) begin
          bv_nxt    = 1'b1;
          bitem_nxt = rd_it;
          if (count_r == CW'(1)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            state_nxt   = S_DONE;
          end else begin
            count_nxt   = count_r - CW'(1);
            mem_rd_addr = AW'(count_r - CW'(2));
            j_nxt       = AW'(count_r - CW'(2));
            state_nxt   = S_INS_WALK;
          end
        end else begin
          status_nxt = ST_REJECT;
          state_nxt  = S_DONE;
        end
      end

      // backward walk: shift larger entries up one, drop the new entry in its slot
      S_INS_WALK: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(j_r + 1'b1);
        if (rd_w > weight_r) begin
          mem_wr_data = rd_data_r;
          if (j_r == '0) begin
            state_nxt = S_INS_HEAD;
          end else begin
            mem_rd_addr = AW'(j_r - 1'b1);
            j_nxt       = AW'(j_r - 1'b1);
          end
        end else begin
          if (!upd_r) begin
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_DONE;
        end
      end

      S_INS_HEAD: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        if (!upd_r) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_DONE;
      end

      // forward scan for the first matching item, one entry a cycle
      S_UPD_SCAN: begin
        prev_nxt = rd_data_r;
        if (rd_it == item_r) begin
          if (j_r == '0) begin
            state_nxt = S_DONE;
          end else if (weight_r < prev_w) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_r;
            mem_wr_data = prev_r;
            upd_nxt     = 1'b1;
            if (j_r == AW'(1)) begin
              state_nxt = S_INS_HEAD;
            end else begin
              mem_rd_addr = AW'(j_r - 2'd2);
              j_nxt       = AW'(j_r - 2'd2);
              state_nxt   = S_INS_WALK;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end else if (CW'(j_r) + CW'(1) == count_r) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          mem_rd_addr = AW'(j_r + 1'b1);
          j_nxt       = AW'(j_r + 1'b1);
        end
      end

      S_POP_HEAD: begin
        oitem_nxt = rd_it;
        ow_nxt    = rd_w;
        if (count_r == CW'(1)) begin
          count_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          mem_rd_addr = AW'(1);
          j_nxt       = AW'(1);
          state_nxt   = S_POP_WALK;
        end
      end

      // shift remaining entries down one
      S_POP_WALK: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(j_r - 1'b1);
        mem_wr_data = rd_data_r;
        if (CW'(j_r) + CW'(1) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_rd_addr = AW'(j_r + 1'b1);
          j_nxt       = AW'(j_r + 1'b1);
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    j_r      <= j_nxt;
    item_r   <= item_nxt;
    weight_r <= weight_nxt;
    upd_r    <= upd_nxt;
    prev_r   <= prev_nxt;
    status_r <= status_nxt;
    bv_r     <= bv_nxt;
    bitem_r  <= bitem_nxt;
    oitem_r  <= oitem_nxt;
    ow_r     <= ow_nxt;
  end

  assign stat_o.ready     = (state_r == S_IDLE);
  assign stat_o.res_valid = (state_r == S_DONE);

  assign res_o.status       = status_r;
  assign res_o.bumped_valid = bv_r;
  assign res_o.bumped_item  = ITEM_W'(bitem_r);
  assign res_o.out_item     = ITEM_W'(oitem_r);
  assign res_o.out_weight   = ow_r;
  assign res_o.count        = COUNT_W'(count_r);
  assign res_o.empty_res    = (count_r == '0);

endmodule

>>> hdl/bounded_priority_queue.sv
// Bounded min-priority queue of (item, weight) pairs, kept in ascending weight
// order with stable ties. Weights are signed Q16.16 and are only compared.
// Input channel in_valid/in_stall/in_data: insert, update weight or pop.
// One result item per input item on out_valid/out_stall/out_data.
// Config channel cfg_valid/cfg_ready/cfg_data writes the capacity; write it only
// while the queue is idle. cfg_ready is always high.
// Steps per item, with n entries stored:
//   insert  backward walk shifting larger entries up
//   update  forward search, then backward move
//   pop     head read, then shift down
// Every walk step is one read plus one write on the entry RAM's two ports, so the
// RAM sets the rate: one item in flight at a time.
// A new item is accepted as soon as the previous result sits in the output register.
// Reset (synchronous, rst_n low) empties the queue and sets capacity to 16; RAM
// contents are left as they are. in_stall is held high during reset.
// While out_stall is high the result holds; the queue finishes at most one more
// item and then waits with in_stall high.
module bounded_priority_queue #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bpq_pkg::bpq_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bpq_pkg::bpq_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bpq_pkg::CAP_W-1:0] cfg_data
);
  import bpq_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  bpq_out_t         out_data_r;
  bpq_stat_t        seq_stat;
  bpq_out_t         seq_res;
  logic             in_take;
  logic             res_ready;

  assign cfg_ready = 1'b1;
  assign in_stall  = !rst_n || !seq_stat.ready;
  assign in_take   = in_valid && !in_stall;
  // output register free, or being emptied this cycle
  assign res_ready = !out_valid_r || !out_stall;

  bpq_seq #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_take),
    .req_i       (in_data),
    .cap_i       (cap_r),
    .res_ready_i (res_ready),
    .stat_o      (seq_stat),
    .res_o       (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (seq_stat.res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (seq_stat.res_valid && res_ready) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // an accepted item keeps the queue busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("queue took a second item straight after the first");

  // eviction only comes with a successful insert
  a_bump_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.bumped_valid |-> out_data_r.status == ST_OK)
    else $error("evicted entry reported with error status");

  // a pop that found nothing leaves the queue empty
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_EMPTY |-> out_data_r.empty_res)
    else $error("pop on empty reported a non-empty queue");
`endif

endmodule
